// ===== rtl/core/afd_pkg.sv =====
// Shared constants, codes and types of the accelerometer fall detector.
// No dependencies; the other RTL files use scoped names, the testbench imports it.
package afd_pkg;

  // Field widths.
  localparam int unsigned AccelWidth  = 16;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned CfgWidth    = 16;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned PhaseWidth  = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxWidth-1:0] CfgImpactThreshold = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgTiltCosine      = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgImpactHold      = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgRestHold        = 2'd3;

  // Configuration reset values.
  localparam logic [CfgWidth-1:0] ImpactThresholdReset = 16'd40960;
  localparam logic [CfgWidth-1:0] TiltCosineReset      = 16'd16384;
  localparam logic [CfgWidth-1:0] ImpactHoldReset      = 16'd200;
  localparam logic [CfgWidth-1:0] RestHoldReset        = 16'd2000;

  // Detector phases.
  localparam logic [PhaseWidth-1:0] PhaseMonitor   = 2'd0;
  localparam logic [PhaseWidth-1:0] PhaseImpact    = 2'd1;
  localparam logic [PhaseWidth-1:0] PhaseRest      = 2'd2;
  localparam logic [PhaseWidth-1:0] PhaseConfirmed = 2'd3;

  // Digit-serial multiplier geometry.
  localparam int unsigned MulWidth    = 32;
  localparam int unsigned DigitWidth  = 8;
  localparam int unsigned MulSteps    = MulWidth / DigitWidth;
  localparam int unsigned MulCntWidth = $clog2(MulSteps);

  // Widths of the derived quantities.
  localparam int unsigned M2Width   = 32;  // x*x + y*y + z*z
  localparam int unsigned SqWidth   = 31;  // square of a 16-bit magnitude
  localparam int unsigned M25Width  = 37;  // 25 * M2
  localparam int unsigned TiltWidth = 62;  // c*c*M2 and z*z*2^30

  // Steady window on 25*M2: 16*G*G and 36*G*G with G = 16384.
  localparam logic [M25Width-1:0] SteadyLo = 37'h0_1_0000_0000;
  localparam logic [M25Width-1:0] SteadyHi = 37'h0_2_4000_0000;

  typedef struct packed {
    logic impact;
    logic released;
    logic at_rest;
  } afd_flags_t;

endpackage

// ===== rtl/core/accel_fall_detector.sv =====
// Accelerometer fall detector, top level. The six products of a sample run one
// after another on a single 32 x 8 digit-serial multiplier, each issued and then
// run digit by digit; a new sample is taken only once the result of the last one
// has been committed to the output register.
// Reset (asynchronous, active low) restores the configuration defaults, the
// monitoring phase, zero event times and empty channels.
module accel_fall_detector (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Sample channel.
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_x_i,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_y_i,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_z_i,
  input  logic [31:0]                           sample_time_ms_i,
  // Result channel.
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  fall_detected_o,
  output logic [afd_pkg::PhaseWidth-1:0]        fall_phase_o,
  // Configuration write port.
  input  logic                                  cfg_we_i,
  input  logic [afd_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [afd_pkg::CfgWidth-1:0]          cfg_wdata_i
);

  localparam int unsigned HoldPad = afd_pkg::TimeWidth - afd_pkg::CfgWidth;

  // Configuration registers.
  logic [afd_pkg::CfgWidth-1:0]        impact_threshold_q;
  logic signed [afd_pkg::CfgWidth-1:0] tilt_cosine_q;
  logic [afd_pkg::CfgWidth-1:0]        impact_hold_q;
  logic [afd_pkg::CfgWidth-1:0]        rest_hold_q;

  // Detector state and the timestamp of the sample in flight.
  logic [afd_pkg::PhaseWidth-1:0] phase_q, phase_d;
  logic [afd_pkg::TimeWidth-1:0]  impact_time_q, impact_time_d;
  logic [afd_pkg::TimeWidth-1:0]  rest_time_q, rest_time_d;
  logic [afd_pkg::TimeWidth-1:0]  time_q;
  logic [afd_pkg::TimeWidth-1:0]  impact_dt, rest_dt;
  logic                           impact_elapsed, rest_elapsed;

  // Handshake and output register.
  logic busy_q, out_valid_q, fall_q, fall_d;
  logic in_take, res_take, eval_valid;
  afd_pkg::afd_flags_t flags;

  // A sample is taken only while no other sample is being evaluated. The
  // output register is separate, so a finished result may wait there while
  // the next sample is already being worked on.
  assign in_ready_o = !busy_q;
  assign in_take    = in_valid_i && in_ready_o;

  // A result is committed to the phase machine and the output register once
  // the register is empty or is being emptied in the same cycle.
  assign res_take = eval_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      impact_threshold_q <= afd_pkg::ImpactThresholdReset;
      tilt_cosine_q      <= afd_pkg::TiltCosineReset;
      impact_hold_q      <= afd_pkg::ImpactHoldReset;
      rest_hold_q        <= afd_pkg::RestHoldReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        afd_pkg::CfgImpactThreshold: impact_threshold_q <= cfg_wdata_i;
        afd_pkg::CfgTiltCosine:      tilt_cosine_q      <= cfg_wdata_i;
        afd_pkg::CfgImpactHold:      impact_hold_q      <= cfg_wdata_i;
        afd_pkg::CfgRestHold:        rest_hold_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The evaluator squares the axes, the threshold and the cosine, then forms
  // the tilt product, and hands back impact, release and rest flags.
  afd_sample_eval u_eval (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (in_take),
    .accel_x_i          (accel_x_i),
    .accel_y_i          (accel_y_i),
    .accel_z_i          (accel_z_i),
    .impact_threshold_i (impact_threshold_q),
    .tilt_cosine_i      (tilt_cosine_q),
    .ack_i              (res_take),
    .valid_o            (eval_valid),
    .flags_o            (flags)
  );

  // Elapsed times wrap at the timestamp width, and a hold is over only when
  // the elapsed time is strictly greater than it.
  assign impact_dt      = time_q - impact_time_q;
  assign rest_dt        = time_q - rest_time_q;
  assign impact_elapsed = impact_dt > {{HoldPad{1'b0}}, impact_hold_q};
  assign rest_elapsed   = rest_dt > {{HoldPad{1'b0}}, rest_hold_q};

  // Phase machine. The confirmed phase always falls back to monitoring on the
  // following sample, without looking for a new impact.
  always_comb begin
    phase_d       = phase_q;
    impact_time_d = impact_time_q;
    rest_time_d   = rest_time_q;
    fall_d        = 1'b0;
    unique case (phase_q)
      afd_pkg::PhaseMonitor: begin
        if (flags.impact) begin
          impact_time_d = time_q;
          phase_d       = afd_pkg::PhaseImpact;
        end
      end
      afd_pkg::PhaseImpact: begin
        if (impact_elapsed) begin
          if (flags.at_rest) begin
            rest_time_d = time_q;
            phase_d     = afd_pkg::PhaseRest;
          end else if (flags.released) begin
            phase_d = afd_pkg::PhaseMonitor;
          end
        end
      end
      afd_pkg::PhaseRest: begin
        if (rest_elapsed) begin
          if (flags.at_rest) begin
            phase_d = afd_pkg::PhaseConfirmed;
            fall_d  = 1'b1;
          end else begin
            phase_d = afd_pkg::PhaseMonitor;
          end
        end
      end
      afd_pkg::PhaseConfirmed: phase_d = afd_pkg::PhaseMonitor;
      default: phase_d = afd_pkg::PhaseMonitor;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      phase_q       <= afd_pkg::PhaseMonitor;
      impact_time_q <= '0;
      rest_time_q   <= '0;
    end else begin
      if (in_take) begin
        busy_q <= 1'b1;
      end else if (res_take) begin
        busy_q <= 1'b0;
      end
      if (res_take) begin
        out_valid_q   <= 1'b1;
        phase_q       <= phase_d;
        impact_time_q <= impact_time_d;
        rest_time_q   <= rest_time_d;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      time_q <= sample_time_ms_i[afd_pkg::TimeWidth-1:0];
    end
    if (res_take) begin
      fall_q <= fall_d;
    end
  end

  // The phase register doubles as the phase field of the result beat: it only
  // changes when a new result enters the output register.
  assign out_valid_o     = out_valid_q;
  assign fall_detected_o = fall_q;
  assign fall_phase_o    = phase_q;

  // Only one sample is evaluated at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> !in_ready_o)
    else $error("second sample accepted while one is in flight");

  // A reported fall always comes with the confirmed phase.
  a_fall_confirmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fall_detected_o |-> fall_phase_o == afd_pkg::PhaseConfirmed)
    else $error("fall reported outside the confirmed phase");

  // The phase moves only when a result is committed.
  a_phase_on_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_take |=> $stable(phase_q))
    else $error("phase changed without a committed result");

  // A confirmed fall is followed by monitoring on the next sample.
  a_confirmed_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_take && phase_q == afd_pkg::PhaseConfirmed |=> phase_q == afd_pkg::PhaseMonitor)
    else $error("confirmed phase did not return to monitoring");

endmodule

// ===== rtl/core/afd_serial_mul.sv =====
// Unsigned 32 x 32 multiplier that consumes one 8-bit digit of the multiplier
// per cycle. Depends on afd_pkg for its geometry.
module afd_serial_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [afd_pkg::MulWidth-1:0]        mcand_i,
  input  logic [afd_pkg::MulWidth-1:0]        mplier_i,
  output logic                                done_o,
  output logic [2*afd_pkg::MulWidth-1:0]      product_o
);

  localparam int unsigned SumWidth = afd_pkg::MulWidth + afd_pkg::DigitWidth;

  logic [afd_pkg::MulWidth-1:0]    hi_q, hi_d, lo_q, lo_d, mcand_q;
  logic [afd_pkg::MulCntWidth-1:0] cnt_q;
  logic                            busy_q, done_q;
  logic [SumWidth-1:0]             partial, sum;

  // The high half absorbs one partial product; the low half shifts the used
  // multiplier digit out and a finished product digit in.
  assign partial = {{afd_pkg::DigitWidth{1'b0}}, mcand_q}
                 * {{afd_pkg::MulWidth{1'b0}}, lo_q[afd_pkg::DigitWidth-1:0]};
  assign sum     = {{afd_pkg::DigitWidth{1'b0}}, hi_q} + partial;
  assign hi_d    = sum[SumWidth-1:afd_pkg::DigitWidth];
  assign lo_d    = {sum[afd_pkg::DigitWidth-1:0], lo_q[afd_pkg::MulWidth-1:afd_pkg::DigitWidth]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == afd_pkg::MulCntWidth'(afd_pkg::MulSteps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
  end

  assign done_o    = done_q;
  assign product_o = {hi_q, lo_q};

endmodule

// ===== rtl/core/afd_sample_eval.sv =====
// Sequencer that forms the squared magnitude, threshold and tilt products of
// one sample on the shared digit-serial multiplier. Depends on afd_pkg.
module afd_sample_eval (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_x_i,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_y_i,
  input  logic signed [afd_pkg::AccelWidth-1:0] accel_z_i,
  input  logic [afd_pkg::CfgWidth-1:0]        impact_threshold_i,
  input  logic signed [afd_pkg::CfgWidth-1:0] tilt_cosine_i,
  input  logic                                ack_i,
  output logic                                valid_o,
  output afd_pkg::afd_flags_t                 flags_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StIssue = 3'd1;
  localparam logic [2:0] StWait  = 3'd2;
  localparam logic [2:0] StFlags = 3'd3;
  localparam logic [2:0] StHold  = 3'd4;

  localparam logic [2:0] OpSqX  = 3'd0;
  localparam logic [2:0] OpSqY  = 3'd1;
  localparam logic [2:0] OpSqZ  = 3'd2;
  localparam logic [2:0] OpSqT  = 3'd3;
  localparam logic [2:0] OpSqC  = 3'd4;
  localparam logic [2:0] OpTilt = 3'd5;

  localparam int unsigned PadW = afd_pkg::MulWidth - afd_pkg::AccelWidth;

  function automatic logic [afd_pkg::AccelWidth-1:0] abs16(
    input logic [afd_pkg::AccelWidth-1:0] v
  );
    abs16 = v[afd_pkg::AccelWidth-1] ? (~v + 1'b1) : v;
  endfunction

  logic [2:0] state_q, op_q;

  logic [afd_pkg::AccelWidth-1:0]  ax_q, ay_q, az_q;
  logic                            z_neg_q;
  logic [afd_pkg::M2Width-1:0]     m2_q, t2_q;
  logic [afd_pkg::M25Width-1:0]    m25_q, m2_ext;
  logic [afd_pkg::SqWidth-1:0]     z2_q, c2_q;
  logic [afd_pkg::TiltWidth-1:0]   tilt_q, lhs2;
  afd_pkg::afd_flags_t             flags_q, flags_d;

  logic                            mul_start, mul_done;
  logic [afd_pkg::MulWidth-1:0]    mcand, mplier;
  logic [2*afd_pkg::MulWidth-1:0]  product;
  logic                            steady, tilted;

  always_comb begin
    unique case (op_q)
      OpSqX:   mcand = {{PadW{1'b0}}, ax_q};
      OpSqY:   mcand = {{PadW{1'b0}}, ay_q};
      OpSqZ:   mcand = {{PadW{1'b0}}, az_q};
      OpSqT:   mcand = {{PadW{1'b0}}, impact_threshold_i};
      OpSqC:   mcand = {{PadW{1'b0}}, abs16(tilt_cosine_i)};
      OpTilt:  mcand = m2_q;
      default: mcand = '0;
    endcase
    mplier = (op_q == OpTilt) ? {1'b0, c2_q} : mcand;
  end

  assign mul_start = (state_q == StIssue);

  afd_serial_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .mcand_i   (mcand),
    .mplier_i  (mplier),
    .done_o    (mul_done),
    .product_o (product)
  );

  // Decision flags from the finished products.
  assign m2_ext = {{(afd_pkg::M25Width - afd_pkg::M2Width){1'b0}}, m2_q};
  assign lhs2   = {1'b0, z2_q, 30'b0};
  assign steady = (m25_q > afd_pkg::SteadyLo) && (m25_q < afd_pkg::SteadyHi);

  always_comb begin
    if (!tilt_cosine_i[afd_pkg::CfgWidth-1]) begin
      tilted = z_neg_q || (lhs2 < tilt_q);
    end else begin
      tilted = z_neg_q && (lhs2 > tilt_q);
    end
    flags_d.impact   = m2_q > t2_q;
    flags_d.released = m25_q < {1'b0, t2_q, 4'b0};
    flags_d.at_rest  = tilted && steady;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= OpSqX;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StIssue;
            op_q    <= OpSqX;
          end
        end
        StIssue: state_q <= StWait;
        StWait: begin
          if (mul_done) begin
            if (op_q == OpTilt) begin
              state_q <= StFlags;
            end else begin
              op_q    <= op_q + 1'b1;
              state_q <= StIssue;
            end
          end
        end
        StFlags: state_q <= StHold;
        StHold: begin
          if (ack_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    m25_q <= (m2_ext << 4) + (m2_ext << 3) + m2_ext;
    if (state_q == StIdle && start_i) begin
      ax_q    <= abs16(accel_x_i);
      ay_q    <= abs16(accel_y_i);
      az_q    <= abs16(accel_z_i);
      z_neg_q <= accel_z_i[afd_pkg::AccelWidth-1];
    end
    if (state_q == StWait && mul_done) begin
      case (op_q)
        OpSqX: m2_q <= product[afd_pkg::M2Width-1:0];
        OpSqY: m2_q <= m2_q + product[afd_pkg::M2Width-1:0];
        OpSqZ: begin
          m2_q <= m2_q + product[afd_pkg::M2Width-1:0];
          z2_q <= product[afd_pkg::SqWidth-1:0];
        end
        OpSqT:  t2_q   <= product[afd_pkg::M2Width-1:0];
        OpSqC:  c2_q   <= product[afd_pkg::SqWidth-1:0];
        OpTilt: tilt_q <= product[afd_pkg::TiltWidth-1:0];
        default: ;
      endcase
    end
    if (state_q == StFlags) begin
      flags_q <= flags_d;
    end
  end

  assign valid_o = (state_q == StHold);
  assign flags_o = flags_q;

endmodule

// ===== tb/tb_accel_fall_detector.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of accel_fall_detector: a phase predictor, directed fall
// sequences, and random sequences under random stalls on both valid/ready channels.
// Depends on afd_pkg and the accel_fall_detector RTL; reads no files.
module tb_accel_fall_detector;
  import afd_pkg::*;

  // A correct run never goes this long without a beat on either channel, even
  // while one sample is being evaluated and stall bursts hold either side.
  localparam int unsigned StallLimit      = 4000;
  // Cycles allowed after the last result before the verdict.
  localparam int unsigned DrainCycles     = 40;
  localparam int unsigned ShownMismatches = 10;

  // Steady window on 25 * |a|^2: (0.8 g)^2 .. (1.2 g)^2, scaled by 25, g = 16384.
  localparam longint unsigned OneG       = 16384;
  localparam longint unsigned SteadyLow  = 16 * OneG * OneG;
  localparam longint unsigned SteadyHigh = 36 * OneG * OneG;

  typedef struct packed {
    logic                  fall;
    logic [PhaseWidth-1:0] phase;
  } verdict_t;

  typedef struct {
    logic signed [AccelWidth-1:0] x;
    logic signed [AccelWidth-1:0] y;
    logic signed [AccelWidth-1:0] z;
  } axes_t;

  // Every input is at a known value from time zero; reset is held low.
  logic                         clk;
  logic                         rst_n         = 1'b0;
  logic                         in_valid      = 1'b0;
  logic                         in_ready;
  logic signed [AccelWidth-1:0] accel_x       = '0;
  logic signed [AccelWidth-1:0] accel_y       = '0;
  logic signed [AccelWidth-1:0] accel_z       = '0;
  logic [31:0]                  sample_time   = '0;
  logic                         out_valid;
  logic                         out_ready     = 1'b0;
  logic                         fall_detected;
  logic [PhaseWidth-1:0]        fall_phase;
  logic                         cfg_we        = 1'b0;
  logic [CfgIdxWidth-1:0]       cfg_idx       = '0;
  logic [CfgWidth-1:0]          cfg_wdata     = '0;

  // When set, both sides insert random idle bursts; the last part runs without.
  bit                           idling        = 1'b1;

  accel_fall_detector u_top (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .accel_x_i        (accel_x),
    .accel_y_i        (accel_y),
    .accel_z_i        (accel_z),
    .sample_time_ms_i (sample_time),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .fall_detected_o  (fall_detected),
    .fall_phase_o     (fall_phase),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. It keeps its own copy of the registers and of the phase machine
  // and is stepped once per accepted sample beat, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [CfgWidth-1:0]        impact_thr;
  logic signed [CfgWidth-1:0] tilt_cos;
  logic [CfgWidth-1:0]        impact_hold;
  logic [CfgWidth-1:0]        rest_hold;
  logic [PhaseWidth-1:0]      det_phase;
  logic [TimeWidth-1:0]       impact_stamp;
  logic [TimeWidth-1:0]       rest_stamp;

  // Results still owed by the block, oldest first.
  verdict_t                   pending_verdicts[$];
  // Timestamp of the last accepted sample; random sequences advance from it.
  logic [31:0]                clock_ms;
  int                         mismatches;

  task automatic restore_defaults();
    impact_thr   = 16'd40960;
    tilt_cos     = 16'sd16384;
    impact_hold  = 16'd200;
    rest_hold    = 16'd2000;
    det_phase    = PhaseMonitor;
    impact_stamp = '0;
    rest_stamp   = '0;
  endtask

  // Rest means "steady near 1 g" and "tilted past the threshold angle". The
  // tilt test compares z * 2^15 against C * |a| without a square root: the signs
  // settle most cases, and the squares settle the rest.
  function automatic bit is_resting(input logic signed [AccelWidth-1:0] z,
                                    input longint unsigned mag_sq);
    longint          zs;
    longint          cs;
    longint unsigned z_abs;
    longint unsigned c_abs;
    longint unsigned lhs_sq;
    longint unsigned rhs_sq;
    longint unsigned mag_sq25;
    bit              steady;
    bit              tilted;
    zs       = z;
    cs       = tilt_cos;
    z_abs    = (zs < 0) ? -zs : zs;
    c_abs    = (cs < 0) ? -cs : cs;
    mag_sq25 = 25 * mag_sq;
    steady   = (mag_sq25 > SteadyLow) && (mag_sq25 < SteadyHigh);
    lhs_sq   = (z_abs * z_abs) << 30;
    rhs_sq   = c_abs * c_abs * mag_sq;
    if (cs >= 0) begin
      tilted = (zs < 0) || (lhs_sq < rhs_sq);
    end else begin
      tilted = (zs < 0) && (lhs_sq > rhs_sq);
    end
    return tilted && steady;
  endfunction

  function automatic verdict_t detector_step(input logic signed [AccelWidth-1:0] x,
                                             input logic signed [AccelWidth-1:0] y,
                                             input logic signed [AccelWidth-1:0] z,
                                             input logic [TimeWidth-1:0]         t);
    longint               xs;
    longint               ys;
    longint               zs;
    longint unsigned      mag_sq;
    longint unsigned      thr;
    longint unsigned      thr_sq;
    logic [TimeWidth-1:0] elapsed;
    verdict_t             verdict;
    xs      = x;
    ys      = y;
    zs      = z;
    mag_sq  = xs * xs + ys * ys + zs * zs;
    thr     = impact_thr;
    thr_sq  = thr * thr;
    verdict.fall = 1'b0;
    case (det_phase)
      PhaseMonitor: begin
        if (mag_sq > thr_sq) begin
          impact_stamp = t;
          det_phase    = PhaseImpact;
        end
      end
      PhaseImpact: begin
        // The time difference wraps at the timestamp width.
        elapsed = t - impact_stamp;
        if (elapsed > impact_hold) begin
          if (is_resting(z, mag_sq)) begin
            rest_stamp = t;
            det_phase  = PhaseRest;
          end else if (25 * mag_sq < 16 * thr_sq) begin
            det_phase = PhaseMonitor;
          end
        end
      end
      PhaseRest: begin
        elapsed = t - rest_stamp;
        if (elapsed > rest_hold) begin
          if (is_resting(z, mag_sq)) begin
            det_phase    = PhaseConfirmed;
            verdict.fall = 1'b1;
          end else begin
            det_phase = PhaseMonitor;
          end
        end
      end
      default: begin
        // A confirmed fall drops back to monitoring without an impact check.
        det_phase = PhaseMonitor;
      end
    endcase
    verdict.phase = det_phase;
    return verdict;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample channel driver. Valid is raised at a clock edge and held with the
  // payload until the edge at which ready is seen high. Valid is not lowered
  // between back-to-back beats, so it gets one assignment per time step.
  // ---------------------------------------------------------------------------
  task automatic send_sample(input logic signed [AccelWidth-1:0] x,
                             input logic signed [AccelWidth-1:0] y,
                             input logic signed [AccelWidth-1:0] z,
                             input logic [31:0]                  t);
    if (idling && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    accel_x     <= x;
    accel_y     <= y;
    accel_z     <= z;
    sample_time <= t;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(detector_step(x, y, z, t));
    clock_ms = t;
  endtask

  // Stops the sample stream and waits until every owed result has come back.
  // Each sample yields exactly one result, so the block is idle after that.
  task automatic wait_results();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges, with the block idle.
  task automatic load_settings(input int thr, input int cos_q15,
                               input int hold_impact, input int hold_rest);
    wait_results();
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgImpactThreshold;
    cfg_wdata <= 16'(thr);
    @(posedge clk);
    cfg_idx   <= CfgTiltCosine;
    cfg_wdata <= 16'(cos_q15);
    @(posedge clk);
    cfg_idx   <= CfgImpactHold;
    cfg_wdata <= 16'(hold_impact);
    @(posedge clk);
    cfg_idx   <= CfgRestHold;
    cfg_wdata <= 16'(hold_rest);
    @(posedge clk);
    cfg_we    <= 1'b0;
    impact_thr  = 16'(thr);
    tilt_cos    = 16'(cos_q15);
    impact_hold = 16'(hold_impact);
    rest_hold   = 16'(hold_rest);
  endtask

  // ---------------------------------------------------------------------------
  // Sample shapes for the random sequences.
  // ---------------------------------------------------------------------------
  function automatic logic signed [AccelWidth-1:0] signed_span(input int lo, input int hi);
    int mag;
    mag = $urandom_range(hi, lo);
    return 16'(($urandom_range(0, 1) != 0) ? -mag : mag);
  endfunction

  // Hard shock: every axis near full scale, beyond every threshold used here.
  function automatic axes_t pick_impact();
    axes_t a;
    a.x = signed_span(28000, 32767);
    a.y = signed_span(28000, 32767);
    a.z = signed_span(28000, 32767);
    return a;
  endfunction

  // About 1 g lying down. With a negative cosine the tilt has to go past 90
  // degrees, so the weight goes to negative z instead.
  function automatic axes_t pick_lying();
    axes_t a;
    a.x = signed_span(0, 4000);
    a.y = signed_span(0, 4000);
    a.z = signed_span(0, 4000);
    if (tilt_cos < 0) begin
      a.z = -signed_span(14000, 18000);
      if (a.z > 0) a.z = -a.z;
    end else if ($urandom_range(0, 1) != 0) begin
      a.x = signed_span(14000, 18000);
    end else begin
      a.y = signed_span(14000, 18000);
    end
    return a;
  endfunction

  // About 1 g standing upright: steady, and not tilted except under a cosine near full scale.
  function automatic axes_t pick_upright();
    axes_t a;
    a.x = signed_span(0, 3000);
    a.y = signed_span(0, 3000);
    a.z = 16'($urandom_range(14000, 18000));
    return a;
  endfunction

  // Weak motion, well below every nonzero impact threshold used here.
  function automatic axes_t pick_quiet();
    axes_t a;
    a.x = signed_span(0, 4000);
    a.y = signed_span(0, 4000);
    a.z = signed_span(0, 4000);
    return a;
  endfunction

  function automatic axes_t pick_noise();
    axes_t a;
    a.x = 16'($urandom);
    a.y = 16'($urandom);
    a.z = 16'($urandom);
    return a;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Under the reset register values: a full fall, the confirmed phase falling
  // back without an impact check, zero magnitude, staying in impact, release,
  // a failed rest check, and hold times that wrap across the timestamp range.
  task automatic test_directed_sequence();
    send_sample(0, 0, 0, 32'd0);
    send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd10);
    send_sample(0, 0, 0, 32'd110);
    send_sample(16384, 0, 0, 32'd211);
    send_sample(0, 16384, 0, 32'd2211);        // exactly at the rest hold: no change
    send_sample(0, -16384, 0, 32'd2212);       // confirms the fall
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd2213);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd2214);
    send_sample(0, 0, 0, 32'd2500);            // zero magnitude releases
    send_sample(16'sh7FFF, 16'sh8000, 0, 32'd3000);
    send_sample(0, 20000, 16'sh7FFF, 32'd3300); // neither rest nor release
    send_sample(0, 0, 16384, 32'd3301);
    send_sample(16'sh8000, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFF0);
    send_sample(16384, 0, -1, 32'h0000_00C0);
    send_sample(0, 0, 16384, 32'h0000_00C0 + 32'd2001);
  endtask

  // Register extremes: a threshold that no sample can exceed, a zero
  // threshold, both ends of the cosine range and both ends of the holds.
  task automatic test_register_extremes();
    load_settings(65535, 32767, 0, 0);
    send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'd100);
    send_sample(16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd101);
    load_settings(0, -32768, 65535, 65535);
    send_sample(0, 0, 0, 32'd200);
    send_sample(1, 0, 0, 32'd201);
    send_sample(0, 0, -16384, 32'd201 + 32'd65535);
    send_sample(0, 0, -16384, 32'd201 + 32'd65536);
  endtask

  // Random sequences steered by the predicted phase, so that most of them walk
  // through impact and rest towards a confirmed fall. Timestamps either creep
  // forward or jump to just past a hold, sometimes landing exactly on it. A
  // few samples are pure noise, some with a random timestamp.
  task automatic test_random_sequences(input int thr, input int cos_q15,
                                       input int hold_impact, input int hold_rest,
                                       input int count);
    axes_t       a;
    logic [31:0] t;
    int          pick;
    load_settings(thr, cos_q15, hold_impact, hold_rest);
    for (int i = 0; i < count; i++) begin
      // Halfway through, the stream pauses until the block has drained.
      if (i == count / 2) wait_results();
      t    = clock_ms + $urandom_range(1, 40);
      pick = $urandom_range(0, 99);
      case (det_phase)
        PhaseMonitor: begin
          if (pick < 60) a = pick_impact();
          else if (pick < 80) a = pick_upright();
          else a = pick_quiet();
        end
        PhaseImpact: begin
          if ($urandom_range(0, 2) == 0) begin
            t = impact_stamp + impact_hold + $urandom_range(0, 2);
          end else if ($urandom_range(0, 2) == 0) begin
            t = impact_stamp + impact_hold + $urandom_range(3, 400);
          end
          if (pick < 60) a = pick_lying();
          else if (pick < 80) a = pick_quiet();
          else if (pick < 90) a = pick_upright();
          else a = pick_impact();
        end
        PhaseRest: begin
          if ($urandom_range(0, 2) == 0) begin
            t = rest_stamp + rest_hold + $urandom_range(0, 2);
          end else if ($urandom_range(0, 2) == 0) begin
            t = rest_stamp + rest_hold + $urandom_range(3, 400);
          end
          if (pick < 70) a = pick_lying();
          else if (pick < 85) a = pick_upright();
          else a = pick_quiet();
        end
        default: begin
          a = pick_noise();
        end
      endcase
      if ($urandom_range(0, 19) == 0) begin
        a = pick_noise();
        if ($urandom_range(0, 1) != 0) t = $urandom;
      end
      send_sample(a.x, a.y, a.z, t);
    end
  endtask

  // The closing stretch: no idle cycles on either side, so beats go back to
  // back at the block's own rate.
  task automatic test_back_to_back();
    wait_results();
    idling = 1'b0;
    test_random_sequences(35000, 16384, 100, 100, 300);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel: ready drops in random bursts while idling is on.
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Every result beat is compared with the oldest owed result, field by field.
  always @(posedge clk) begin
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownMismatches) begin
          $display("%0t: result beat with nothing owed (fall %0b, phase %0d)",
                   $realtime, fall_detected, fall_phase);
        end
      end else begin
        want = pending_verdicts.pop_front();
        if (fall_detected !== want.fall || fall_phase !== want.phase) begin
          mismatches++;
          if (mismatches <= ShownMismatches) begin
            $display("%0t: fall expected %0b got %0b, phase expected %0d got %0d",
                     $realtime, want.fall, fall_detected, want.phase, fall_phase);
          end
        end
      end
    end
  end

  // Watchdog: too many cycles in a row without a beat on either channel.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("accel_fall_detector verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    mismatches = 0;
    clock_ms   = '0;
    restore_defaults();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_sequence();
    test_register_extremes();
    test_random_sequences(40960, 16384, 200, 2000, 400);
    test_random_sequences(30000, 23170, 0, 0, 300);
    // Long holds that start just below the top of the timestamp range.
    wait_results();
    clock_ms = 32'hFFFF_0000;
    test_random_sequences(45000, -8192, 65535, 65535, 250);
    test_random_sequences(20000, 32767, 50, 300, 250);
    test_random_sequences(48000, 0, 10, 10, 250);
    test_random_sequences(0, -32768, 5, 5, 150);
    test_back_to_back();

    wait_results();
    repeat (DrainCycles) @(posedge clk);
    mismatches += pending_verdicts.size();
    if (mismatches == 0) begin
      $display("accel_fall_detector verification clean");
    end else begin
      $display("accel_fall_detector verification failed");
    end
    $finish;
  end

endmodule
